[src/tsqw_pkg.sv]
// shared types, register indexes and reset values for the turn signal qualifier
`timescale 1ns / 1ps
package tsqw_pkg;

  localparam int unsigned MAX_WIPE_DEF   = 64;
  localparam int unsigned TIMER_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEN_CFG_W = 7;
  localparam int unsigned IN_W      = 8;
  localparam int unsigned NUM_WIRES = 4;

  // wire positions in the input request
  localparam int unsigned WIRE_HEAD  = 0;
  localparam int unsigned WIRE_BRAKE = 1;
  localparam int unsigned WIRE_LEFT  = 2;
  localparam int unsigned WIRE_RIGHT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE,
    REG_RETURN_DELAY,
    REG_HAZARD_WINDOW,
    REG_FLASH_PERIOD,
    REG_WIPE_STEP,
    REG_EXIT_STYLE,
    REG_HOLD_PATTERN,
    REG_WIPE_LENGTH
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LEFT,
    KIND_RIGHT,
    KIND_HAZARD
  } signal_kind_e;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_IN,
    PHASE_OUT
  } wipe_phase_e;

  localparam logic [1:0] EXIT_REVERSE = 2'd0;
  localparam logic [1:0] EXIT_PUSH    = 2'd1;
  localparam logic [1:0] EXIT_BLANK   = 2'd2;

  localparam logic [CFG_W-1:0]     DEBOUNCE_RST      = 16'd50;
  localparam logic [CFG_W-1:0]     RETURN_DELAY_RST  = 16'd500;
  localparam logic [CFG_W-1:0]     HAZARD_WINDOW_RST = 16'd50;
  localparam logic [CFG_W-1:0]     FLASH_PERIOD_RST  = 16'd25;
  localparam logic [CFG_W-1:0]     WIPE_STEP_RST     = 16'd10;
  localparam logic [1:0]           EXIT_STYLE_RST    = EXIT_PUSH;
  localparam logic                 HOLD_PATTERN_RST  = 1'b0;
  localparam logic [LEN_CFG_W-1:0] WIPE_LENGTH_RST   = 7'd10;

  // turn status handed from the qualifier to the wipe sequencer
  typedef struct packed {
    signal_kind_e kind;
    logic         rise;
    logic         fall;
    logic         active;
  } turn_info_t;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic                 show_full;
    logic [6:0]           draw_past;
    logic [6:0]           draw_first;
    wipe_phase_e          wipe_phase;
    logic                 flash_on;
    logic                 mode_changed;
    logic                 tail_mode;
    signal_kind_e         signal_kind;
    logic                 brake_level;
    logic                 head_level;
  } lamp_result_t;

endpackage

[src/tsqw_debounce.sv]
// debounce timer for one lamp wire
`timescale 1ns / 1ps
module tsqw_debounce import tsqw_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             raw_i,
  input  logic [CFG_W-1:0] debounce_i,
  output logic             level_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  cand_q, cand_d;
  logic                  level_q, level_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;

  always_comb begin
    cand_d = raw_i;
    if (raw_i != cand_q) begin
      timer_d = '0;
    end else if (&timer_q) begin
      timer_d = timer_q;
    end else begin
      timer_d = timer_q + TIMER_BITS'(1);
    end
    level_d = (CMP_W'(timer_d) >= CMP_W'(debounce_i)) ? cand_d : level_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q  <= 1'b0;
      level_q <= 1'b0;
      timer_q <= '0;
    end else if (en_i) begin
      cand_q  <= cand_d;
      level_q <= level_d;
      timer_q <= timer_d;
    end
  end

  assign level_o = level_d;

endmodule

[src/tsqw_qualify.sv]
// turn signal classification, tail mode and brake flash
`timescale 1ns / 1ps
module tsqw_qualify import tsqw_pkg::*; #(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             head_i,
  input  logic             brake_i,
  input  logic             left_i,
  input  logic             right_i,
  input  logic [CFG_W-1:0] return_delay_i,
  input  logic [CFG_W-1:0] hazard_window_i,
  input  logic [CFG_W-1:0] flash_period_i,
  output logic             mode_changed_o,
  output logic             flash_o,
  output turn_info_t       turn_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + TIMER_BITS'(1);
  endfunction

  logic [1:0]            prior_q, prior_d;
  logic [TIMER_BITS-1:0] since_start_q, since_start_d;
  logic [TIMER_BITS-1:0] since_fall_q, since_fall_d;
  logic [TIMER_BITS-1:0] since_flash_q, since_flash_d;
  logic                  window_q, window_d;
  signal_kind_e          kind_q, kind_d;
  logic                  tail_q;
  logic                  flash_q, flash_d;
  logic                  blink_now, blink_before, rise, fall;

  assign blink_now    = left_i | right_i;
  assign blink_before = |prior_q;
  assign rise         = blink_now & ~blink_before;
  assign fall         = blink_before & ~blink_now;
  assign prior_d      = {right_i, left_i};

  always_comb begin
    since_start_d = rise ? '0 : sat_inc(since_start_q);
    since_fall_d  = fall ? '0 : sat_inc(since_fall_q);
    window_d      = window_q | rise;
    kind_d        = kind_q;
    // classify when the hazard window closes, keep the kind if both turns dropped
    if (window_d && (CMP_W'(since_start_d) >= CMP_W'(hazard_window_i))) begin
      window_d = 1'b0;
      priority if (left_i && right_i) begin
        kind_d = KIND_HAZARD;
      end else if (left_i) begin
        kind_d = KIND_LEFT;
      end else if (right_i) begin
        kind_d = KIND_RIGHT;
      end else begin
        kind_d = kind_q;
      end
    end
    if (!blink_now && (CMP_W'(since_fall_d) >= CMP_W'(return_delay_i))) begin
      kind_d   = KIND_NONE;
      window_d = 1'b0;
    end
  end

  always_comb begin
    since_flash_d = sat_inc(since_flash_q);
    flash_d       = flash_q;
    if (brake_i) begin
      if (CMP_W'(since_flash_d) >= CMP_W'(flash_period_i)) begin
        flash_d       = ~flash_q;
        since_flash_d = '0;
      end
    end else begin
      flash_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q       <= '0;
      since_start_q <= '0;
      since_fall_q  <= '1;
      since_flash_q <= '0;
      window_q      <= 1'b0;
      kind_q        <= KIND_NONE;
      tail_q        <= 1'b0;
      flash_q       <= 1'b0;
    end else if (en_i) begin
      prior_q       <= prior_d;
      since_start_q <= since_start_d;
      since_fall_q  <= since_fall_d;
      since_flash_q <= since_flash_d;
      window_q      <= window_d;
      kind_q        <= kind_d;
      tail_q        <= head_i;
      flash_q       <= flash_d;
    end
  end

  assign mode_changed_o = head_i ^ tail_q;
  assign flash_o        = flash_d;
  assign turn_o.kind    = kind_d;
  assign turn_o.rise    = rise;
  assign turn_o.fall    = fall;
  assign turn_o.active  = blink_now;

endmodule

[src/tsqw_wipe.sv]
// column wipe sequencer and draw range
`timescale 1ns / 1ps
module tsqw_wipe import tsqw_pkg::*; #(
  parameter int unsigned MAX_WIPE   = MAX_WIPE_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  turn_info_t           turn_i,
  input  logic [CFG_W-1:0]     wipe_step_i,
  input  logic [1:0]           exit_style_i,
  input  logic                 hold_i,
  input  logic [LEN_CFG_W-1:0] wipe_length_i,
  output wipe_phase_e          phase_o,
  output logic [6:0]           draw_first_o,
  output logic [6:0]           draw_past_o,
  output logic                 show_full_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int unsigned COL_W = $clog2(MAX_WIPE + 1);
  localparam int unsigned LEN_W = (COL_W > LEN_CFG_W) ? COL_W : LEN_CFG_W;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + TIMER_BITS'(1);
  endfunction

  logic [1:0]            req_q, req_d;
  wipe_phase_e           mode_q, mode_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [TIMER_BITS-1:0] step_q, step_d;
  signal_kind_e          kind_before_q;
  logic [LEN_W-1:0]      len_x, len_sat;
  logic [COL_W-1:0]      w;
  logic [COL_W-1:0]      first, past;
  logic                  full;

  // pattern length saturated into one..MAX_WIPE
  assign len_x   = LEN_W'(wipe_length_i);
  assign len_sat = (len_x == '0) ? LEN_W'(1) :
                   (len_x > LEN_W'(MAX_WIPE)) ? LEN_W'(MAX_WIPE) : len_x;
  assign w       = COL_W'(len_sat);

  // next state
  always_comb begin
    req_d  = req_q | {turn_i.fall & ~hold_i, turn_i.rise};
    mode_d = mode_q;
    col_d  = col_q;
    step_d = sat_inc(step_q);
    if (turn_i.kind != KIND_NONE) begin
      if (turn_i.kind != kind_before_q) begin
        col_d  = '0;
        mode_d = PHASE_IN;
        req_d  = '0;
      end
      if (req_d[0]) begin
        col_d    = '0;
        mode_d   = PHASE_IN;
        req_d[0] = 1'b0;
      end
      if (req_d[1] && !hold_i) begin
        mode_d = PHASE_OUT;
        col_d  = (exit_style_i == EXIT_REVERSE) ? w : '0;
      end
      req_d[1] = 1'b0;
      if (turn_i.kind != KIND_HAZARD) begin
        if (CMP_W'(step_d) >= CMP_W'(wipe_step_i)) begin
          step_d = '0;
          unique case (mode_d)
            PHASE_IN: begin
              if (col_d < w) col_d = col_d + COL_W'(1);
              else mode_d = PHASE_IDLE;
            end
            PHASE_OUT: begin
              priority if (exit_style_i == EXIT_REVERSE) begin
                if (col_d != '0) col_d = col_d - COL_W'(1);
                else mode_d = PHASE_IDLE;
              end else if (exit_style_i == EXIT_PUSH) begin
                if (col_d < w) begin
                  col_d = col_d + COL_W'(1);
                end else begin
                  col_d  = '0;
                  mode_d = PHASE_IDLE;
                end
              end else begin
                // hard blank, also for the unused style code
                col_d  = '0;
                mode_d = PHASE_IDLE;
              end
            end
            default: ;
          endcase
        end
        if (col_d > w) col_d = w;
      end
    end
  end

  // draw range
  always_comb begin
    first = '0;
    past  = '0;
    full  = 1'b0;
    if (turn_i.kind == KIND_HAZARD) begin
      if (turn_i.active) begin
        past = w;
        full = 1'b1;
      end
    end else if (turn_i.kind != KIND_NONE) begin
      unique case (mode_d)
        PHASE_IDLE: begin
          if (col_d == w) begin
            past = w;
            full = 1'b1;
          end
        end
        PHASE_OUT: begin
          if (exit_style_i == EXIT_PUSH) begin
            first = col_d;
            past  = w;
          end else begin
            past = col_d;
          end
        end
        default: past = col_d;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q         <= '0;
      mode_q        <= PHASE_IDLE;
      col_q         <= '0;
      step_q        <= '0;
      kind_before_q <= KIND_NONE;
    end else if (en_i) begin
      req_q         <= req_d;
      mode_q        <= mode_d;
      col_q         <= col_d;
      step_q        <= step_d;
      kind_before_q <= turn_i.kind;
    end
  end

  assign phase_o      = mode_d;
  assign draw_first_o = 7'(first);
  assign draw_past_o  = 7'(past);
  assign show_full_o  = full;

  // column never runs past the longest pattern
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    COL_W'(MAX_WIPE) >= col_q)
    else $error("wipe column beyond pattern limit");

endmodule

[src/turn_signal_qualifier_wipe.sv]
// top level: config registers, wire debounce, qualifier, wipe and result register
`timescale 1ns / 1ps
// an accepted tick request's result reaches the master side in the cycle after it is taken
// throughput: one tick per cycle; the only stage is the result register, which
//   takes a new result whenever it is empty or being drained in the same cycle
// reset: asynchronous active-low; all timers, levels and sequencer state clear,
//   the return timer starts saturated, config registers load their defaults
module turn_signal_qualifier_wipe import tsqw_pkg::*; #(
  parameter int unsigned MAX_WIPE   = MAX_WIPE_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // tick requests
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] head_raw, [1] brake_raw, [2] left_raw, [3] right_raw, [7:4] zero
  input  logic [IN_W-1:0]      s_axis_tdata,
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] head_level, [1] brake_level, [3:2] signal_kind, [4] tail_mode,
  // [5] mode_changed, [6] flash_on, [8:7] wipe_phase, [15:9] draw_first,
  // [22:16] draw_past, [23] show_full
  output logic [$bits(lamp_result_t)-1:0] m_axis_tdata
);

  // config registers
  logic [CFG_W-1:0]     debounce_q, return_delay_q, hazard_window_q;
  logic [CFG_W-1:0]     flash_period_q, wipe_step_q;
  logic [1:0]           exit_style_q;
  logic                 hold_q;
  logic [LEN_CFG_W-1:0] wipe_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q      <= DEBOUNCE_RST;
      return_delay_q  <= RETURN_DELAY_RST;
      hazard_window_q <= HAZARD_WINDOW_RST;
      flash_period_q  <= FLASH_PERIOD_RST;
      wipe_step_q     <= WIPE_STEP_RST;
      exit_style_q    <= EXIT_STYLE_RST;
      hold_q          <= HOLD_PATTERN_RST;
      wipe_length_q   <= WIPE_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE:      debounce_q      <= cfg_data_i;
        REG_RETURN_DELAY:  return_delay_q  <= cfg_data_i;
        REG_HAZARD_WINDOW: hazard_window_q <= cfg_data_i;
        REG_FLASH_PERIOD:  flash_period_q  <= cfg_data_i;
        REG_WIPE_STEP:     wipe_step_q     <= cfg_data_i;
        REG_EXIT_STYLE:    exit_style_q    <= cfg_data_i[1:0];
        REG_HOLD_PATTERN:  hold_q          <= cfg_data_i[0];
        REG_WIPE_LENGTH:   wipe_length_q   <= cfg_data_i[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: a tick is taken whenever the result register can take its result
  logic         out_valid_q;
  lamp_result_t out_q, out_d;
  logic         tick;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign tick          = s_axis_tvalid & s_axis_tready;

  // one debounce timer per wire
  logic [NUM_WIRES-1:0] level;

  for (genvar g = 0; g < NUM_WIRES; g++) begin : g_wire
    tsqw_debounce #(
      .TIMER_BITS(TIMER_BITS)
    ) u_debounce (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (tick),
      .raw_i     (s_axis_tdata[g]),
      .debounce_i(debounce_q),
      .level_o   (level[g])
    );
  end

  // turn classification, tail mode and brake flash
  turn_info_t turn;
  logic       mode_changed, flash_on;

  tsqw_qualify #(
    .TIMER_BITS(TIMER_BITS)
  ) u_qualify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (tick),
    .head_i         (level[WIRE_HEAD]),
    .brake_i        (level[WIRE_BRAKE]),
    .left_i         (level[WIRE_LEFT]),
    .right_i        (level[WIRE_RIGHT]),
    .return_delay_i (return_delay_q),
    .hazard_window_i(hazard_window_q),
    .flash_period_i (flash_period_q),
    .mode_changed_o (mode_changed),
    .flash_o        (flash_on),
    .turn_o         (turn)
  );

  // column wipe
  wipe_phase_e phase;
  logic [6:0]  draw_first, draw_past;
  logic        show_full;

  tsqw_wipe #(
    .MAX_WIPE  (MAX_WIPE),
    .TIMER_BITS(TIMER_BITS)
  ) u_wipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (tick),
    .turn_i       (turn),
    .wipe_step_i  (wipe_step_q),
    .exit_style_i (exit_style_q),
    .hold_i       (hold_q),
    .wipe_length_i(wipe_length_q),
    .phase_o      (phase),
    .draw_first_o (draw_first),
    .draw_past_o  (draw_past),
    .show_full_o  (show_full)
  );

  always_comb begin
    out_d.head_level   = level[WIRE_HEAD];
    out_d.brake_level  = level[WIRE_BRAKE];
    out_d.signal_kind  = turn.kind;
    out_d.tail_mode    = level[WIRE_HEAD];
    out_d.mode_changed = mode_changed;
    out_d.flash_on     = flash_on;
    out_d.wipe_phase   = phase;
    out_d.draw_first   = draw_first;
    out_d.draw_past    = draw_past;
    out_d.show_full    = show_full;
  end

  // result register, payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // an accepted tick always leaves a result behind
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_q)
    else $error("accepted tick produced no result");

  // full pattern means a non-empty range starting at column zero
  a_full_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.show_full) |-> (out_q.draw_first == '0 && out_q.draw_past != '0))
    else $error("show_full with a partial draw range");

  // flash only runs while the brake is held
  a_flash_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flash_on) |-> out_q.brake_level)
    else $error("brake flash lit with brake released");

endmodule
